### rtl/core/nbb_pkg.sv
// ============================================================================
// nbb_pkg: shared types and constants of the nibble block blitter
// Item formats, command codes, register indexes and memory sizes.
// ============================================================================
package nbb_pkg;

    localparam int VRAM_BYTES   = 32768;
    localparam int ROM_BYTES    = 32768;
    localparam int ADDR_W       = 15;
    localparam int APB_AW       = 3;
    localparam int APB_DW       = 32;
    localparam int QUEUE_DEPTH  = 4;
    localparam int BLIT_SIDE    = 16;
    localparam int BLIT_NIBBLES = BLIT_SIDE * BLIT_SIDE;

    localparam logic [15:0] SRC_ALIGN_MASK = 16'hfffc;
    localparam logic [15:0] ROW_SKIP       = 16'd240;
    localparam logic [7:0]  SCROLL_LIMIT   = 8'd192;

    // Action codes of an input item.
    localparam logic [2:0] ACT_REG_WRITE = 3'd0;
    localparam logic [2:0] ACT_VRAM_WR   = 3'd1;
    localparam logic [2:0] ACT_VRAM_RD   = 3'd2;
    localparam logic [2:0] ACT_ROM_LOAD  = 3'd3;
    localparam logic [2:0] ACT_PIXEL     = 3'd4;

    // Blitter register indexes.
    localparam logic [1:0] REG_DST_HI = 2'd0;
    localparam logic [1:0] REG_DST_LO = 2'd1;
    localparam logic [1:0] REG_SRC_HI = 2'd2;
    localparam logic [1:0] REG_SRC_LO = 2'd3;

    // Configuration register select (paddr bit 2).
    localparam logic CFG_SCROLL = 1'b0;
    localparam logic CFG_FLIP   = 1'b1;

    typedef enum logic [2:0] {
        CMD_NOP     = 3'd0,
        CMD_VRAM_WR = 3'd1,
        CMD_VRAM_RD = 3'd2,
        CMD_ROM_WR  = 3'd3,
        CMD_PIXEL   = 3'd4,
        CMD_BLIT    = 3'd5
    } t_cmd;

    typedef struct packed {
        logic [2:0]        action;
        logic [1:0]        reg_index;
        logic [ADDR_W-1:0] byte_address;
        logic [7:0]        data;
        logic [7:0]        pixel_x;
        logic [7:0]        pixel_y;
    } t_in_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic [3:0] pixel_color;
        logic       blit_performed;
    } t_out_item;

    typedef struct packed {
        t_cmd              cmd;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
        logic              nib_hi;
        logic [15:0]       src;
        logic [15:0]       dst;
        logic              copy;
    } t_entry;

    typedef struct packed {
        logic clearing;
    } t_back_status;

endpackage

### rtl/core/nbb_if.sv
// ============================================================================
// nbb_if: valid/ready channels of the nibble block blitter
// One interface for input items and one for result items.
// ============================================================================
interface nbb_in_if;
    logic              valid;
    logic              ready;
    nbb_pkg::t_in_item item;

    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

interface nbb_out_if;
    logic               valid;
    logic               ready;
    nbb_pkg::t_out_item item;

    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

### rtl/core/nbb_front.sv
// ============================================================================
// nbb_front: input decode and configuration registers
// Accepts items, keeps the blitter address registers, resolves pixel
// addresses and turns each item into a command for the back end.
// ============================================================================
module nbb_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    nbb_in_if.sink                        i_in,
    input  nbb_pkg::t_back_status         i_status,
    input  logic                          i_full,
    output logic                          o_push,
    output nbb_pkg::t_entry               o_entry,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [nbb_pkg::APB_AW-1:0]    paddr,
    input  logic [nbb_pkg::APB_DW-1:0]    pwdata,
    output logic [nbb_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);

    logic [7:0] r_scroll;
    logic       r_flip;
    logic [7:0] r_dst_hi;
    logic [7:0] r_dst_lo;
    logic [7:0] r_src_hi;

    logic       cfg_wr;
    logic [7:0] flip_mask;
    logic [7:0] ex;
    logic [7:0] ey;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        prdata = '0;
        if (paddr[2] == nbb_pkg::CFG_FLIP) begin
            prdata[0] = r_flip;
        end else begin
            prdata[7:0] = r_scroll;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scroll <= '0;
            r_flip   <= 1'b0;
        end else if (cfg_wr) begin
            if (paddr[2] == nbb_pkg::CFG_FLIP) begin
                r_flip <= pwdata[0];
            end else begin
                r_scroll <= pwdata[7:0];
            end
        end
    end

    // Nothing is taken while the video RAM clearing pass runs.
    assign i_in.ready = !i_full && !i_status.clearing;
    assign o_push     = i_in.valid && i_in.ready;

    // Screen flip inverts both coordinates; scroll only applies left of column 192.
    assign flip_mask = {8{r_flip}};
    assign ex        = i_in.item.pixel_x ^ flip_mask;
    assign ey        = (i_in.item.pixel_y ^ flip_mask)
                       + ((ex < nbb_pkg::SCROLL_LIMIT) ? r_scroll : 8'd0);

    always_comb begin
        o_entry        = '0;
        o_entry.cmd    = nbb_pkg::CMD_NOP;
        o_entry.addr   = i_in.item.byte_address;
        o_entry.data   = i_in.item.data;
        o_entry.src    = {r_src_hi, i_in.item.data} & nbb_pkg::SRC_ALIGN_MASK;
        o_entry.dst    = {r_dst_hi, r_dst_lo};
        o_entry.copy   = i_in.item.data[0];
        unique case (i_in.item.action)
            nbb_pkg::ACT_REG_WRITE: begin
                if (i_in.item.reg_index == nbb_pkg::REG_SRC_LO) begin
                    o_entry.cmd = nbb_pkg::CMD_BLIT;
                end
            end
            nbb_pkg::ACT_VRAM_WR: o_entry.cmd = nbb_pkg::CMD_VRAM_WR;
            nbb_pkg::ACT_VRAM_RD: o_entry.cmd = nbb_pkg::CMD_VRAM_RD;
            nbb_pkg::ACT_ROM_LOAD: o_entry.cmd = nbb_pkg::CMD_ROM_WR;
            nbb_pkg::ACT_PIXEL: begin
                o_entry.cmd    = nbb_pkg::CMD_PIXEL;
                o_entry.addr   = {ey, ex[7:1]};
                o_entry.nib_hi = ex[0];
            end
            default: o_entry.cmd = nbb_pkg::CMD_NOP;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dst_hi <= '0;
            r_dst_lo <= '0;
            r_src_hi <= '0;
        end else if (o_push && i_in.item.action == nbb_pkg::ACT_REG_WRITE) begin
            unique case (i_in.item.reg_index)
                nbb_pkg::REG_DST_HI: r_dst_hi <= i_in.item.data;
                nbb_pkg::REG_DST_LO: r_dst_lo <= i_in.item.data;
                nbb_pkg::REG_SRC_HI: r_src_hi <= i_in.item.data;
                default: ;
            endcase
        end
    end

endmodule

### rtl/core/nbb_queue.sv
// ============================================================================
// nbb_queue: command queue between front and back end
// A small FIFO of decoded commands, kept in order.
// ============================================================================
module nbb_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  nbb_pkg::t_entry i_entry,
    output logic            o_full,
    input  logic            i_pop,
    output nbb_pkg::t_entry o_entry,
    output logic            o_empty
);

    localparam int QAW = $clog2(nbb_pkg::QUEUE_DEPTH);

    nbb_pkg::t_entry r_slot [nbb_pkg::QUEUE_DEPTH];
    logic [QAW-1:0]  r_wr_ptr;
    logic [QAW-1:0]  r_rd_ptr;
    logic [QAW:0]    r_count;

    assign o_full  = (r_count == (QAW+1)'(nbb_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_entry = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == QAW'(nbb_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == QAW'(nbb_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_entry;
        end
    end

endmodule

### rtl/core/nbb_back.sv
// ============================================================================
// nbb_back: command execution against video RAM and graphics ROM
// Runs the clearing pass, byte accesses, pixel reads and the two-stage
// blit pipeline, and holds the result register.
// ============================================================================
module nbb_back #(
    parameter int VRAM_BYTES = nbb_pkg::VRAM_BYTES,
    parameter int ROM_BYTES  = nbb_pkg::ROM_BYTES
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  nbb_pkg::t_entry       i_entry,
    input  logic                  i_empty,
    output logic                  o_pop,
    output nbb_pkg::t_back_status o_status,
    nbb_out_if.source             o_out
);

    localparam int VAW   = $clog2(VRAM_BYTES);
    localparam int RAW   = $clog2(ROM_BYTES);
    localparam int CNT_W = $clog2(nbb_pkg::BLIT_NIBBLES) + 1;
    localparam int COL_W = $clog2(nbb_pkg::BLIT_SIDE);

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_READ  = 4'b0100,
        ST_BLIT  = 4'b1000
    } t_state;

    logic [7:0] r_vram [VRAM_BYTES];
    logic [7:0] r_rom  [ROM_BYTES];

    t_state             r_state;
    t_state             n_state;
    logic [VAW-1:0]     r_clr_addr;
    logic [15:0]        r_src;
    logic [15:0]        r_dst;
    logic               r_copy;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_s2_valid;
    logic               r_s2_src_odd;
    logic [15:0]        r_s2_dst;
    logic               r_fwd_valid;
    logic [VAW-1:0]     r_fwd_addr;
    logic [7:0]         r_fwd_data;
    logic               r_rd_pixel;
    logic               r_rd_nib_hi;
    logic [7:0]         r_vram_rdata;
    logic [7:0]         r_rom_rdata;
    logic               r_out_valid;
    logic               n_out_valid;
    nbb_pkg::t_out_item r_out;
    nbb_pkg::t_out_item n_out;

    logic           out_free;
    logic           out_load;
    logic           issue;
    logic           blit_done;
    logic [3:0]     nib;
    logic [3:0]     put;
    logic [7:0]     old_byte;
    logic [7:0]     merged;
    logic           s2_we;
    logic           vram_we;
    logic [VAW-1:0] vram_waddr;
    logic [7:0]     vram_wdata;
    logic [VAW-1:0] vram_raddr;
    logic           rom_we;

    assign o_status.clearing = (r_state == ST_CLEAR);
    assign o_out.valid       = r_out_valid;
    assign o_out.item        = r_out;

    // The result register is the only thing the back end fills, so a slot
    // that is free when a command is popped stays free until its result lands.
    assign out_free  = !r_out_valid || o_out.ready;
    assign o_pop     = (r_state == ST_IDLE) && !i_empty && out_free;
    assign issue     = !r_cnt[CNT_W-1];
    assign blit_done = r_cnt[CNT_W-1] && !r_s2_valid;

    // Second blit stage. The byte written on the previous cycle is not yet
    // visible in the read data, so it is forwarded.
    assign nib      = r_s2_src_odd ? r_rom_rdata[3:0] : r_rom_rdata[7:4];
    assign old_byte = (r_fwd_valid && r_fwd_addr == r_s2_dst[VAW:1]) ? r_fwd_data
                                                                     : r_vram_rdata;
    assign put      = r_copy ? nib : 4'd0;
    assign merged   = r_s2_dst[0] ? {put, old_byte[3:0]} : {old_byte[7:4], put};
    assign s2_we    = (r_state == ST_BLIT) && r_s2_valid && (nib != 4'd0);

    assign vram_raddr = (r_state == ST_BLIT) ? r_dst[VAW:1] : i_entry.addr[VAW-1:0];
    assign rom_we     = o_pop && (i_entry.cmd == nbb_pkg::CMD_ROM_WR);

    always_comb begin
        vram_we    = 1'b0;
        vram_waddr = r_clr_addr;
        vram_wdata = 8'd0;
        unique case (r_state)
            ST_CLEAR: vram_we = 1'b1;
            ST_IDLE: begin
                if (o_pop && i_entry.cmd == nbb_pkg::CMD_VRAM_WR) begin
                    vram_we    = 1'b1;
                    vram_waddr = i_entry.addr[VAW-1:0];
                    vram_wdata = i_entry.data;
                end
            end
            ST_BLIT: begin
                if (s2_we) begin
                    vram_we    = 1'b1;
                    vram_waddr = r_s2_dst[VAW:1];
                    vram_wdata = merged;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        n_state  = r_state;
        out_load = 1'b0;
        n_out    = '0;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == VAW'(VRAM_BYTES - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (o_pop) begin
                    unique case (i_entry.cmd) inside
                        nbb_pkg::CMD_VRAM_RD, nbb_pkg::CMD_PIXEL: n_state = ST_READ;
                        nbb_pkg::CMD_BLIT: n_state = ST_BLIT;
                        default: out_load = 1'b1;
                    endcase
                end
            end
            ST_READ: begin
                out_load = 1'b1;
                n_state  = ST_IDLE;
                if (r_rd_pixel) begin
                    n_out.pixel_color = r_rd_nib_hi ? r_vram_rdata[7:4] : r_vram_rdata[3:0];
                end else begin
                    n_out.read_data = r_vram_rdata;
                end
            end
            ST_BLIT: begin
                if (blit_done) begin
                    out_load             = 1'b1;
                    n_out.blit_performed = 1'b1;
                    n_state              = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid && !o_out.ready;
        if (out_load) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
            r_s2_valid  <= 1'b0;
            r_fwd_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (o_pop && i_entry.cmd == nbb_pkg::CMD_BLIT) begin
                r_cnt       <= '0;
                r_s2_valid  <= 1'b0;
                r_fwd_valid <= 1'b0;
            end else if (r_state == ST_BLIT) begin
                r_s2_valid  <= issue;
                r_fwd_valid <= s2_we;
                if (issue) begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= n_out;
        end
        if (o_pop) begin
            r_rd_pixel  <= (i_entry.cmd == nbb_pkg::CMD_PIXEL);
            r_rd_nib_hi <= i_entry.nib_hi;
        end
        if (o_pop && i_entry.cmd == nbb_pkg::CMD_BLIT) begin
            r_src  <= i_entry.src;
            r_dst  <= i_entry.dst;
            r_copy <= i_entry.copy;
        end else if (r_state == ST_BLIT && issue) begin
            r_src        <= r_src + 16'd1;
            // The last column of a row also skips the rest of the 256-nibble line.
            r_dst        <= (r_cnt[COL_W-1:0] == COL_W'(nbb_pkg::BLIT_SIDE - 1))
                            ? r_dst + 16'd1 + nbb_pkg::ROW_SKIP : r_dst + 16'd1;
            r_s2_src_odd <= r_src[0];
            r_s2_dst     <= r_dst;
        end
        if (s2_we) begin
            r_fwd_addr <= r_s2_dst[VAW:1];
            r_fwd_data <= merged;
        end
    end

    always_ff @(posedge i_clk) begin
        if (vram_we) begin
            r_vram[vram_waddr] <= vram_wdata;
        end
        r_vram_rdata <= r_vram[vram_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (rom_we) begin
            r_rom[i_entry.addr[RAW-1:0]] <= i_entry.data;
        end
        r_rom_rdata <= r_rom[r_src[RAW:1]];
    end

endmodule

### rtl/core/nibble_block_blitter_with_scanout.sv
// ============================================================================
// nibble_block_blitter_with_scanout: nibble blitter with video RAM scanout
// Front end decodes items, a command queue decouples it from the back end,
// which owns the video RAM, the graphics ROM and the result register.
//
//   Channel   Direction  Handshake                 Payload
//   i_in      in         valid/ready               action, reg_index, byte_address,
//                                                  data, pixel_x, pixel_y
//   o_out     out        valid/ready               read_data, pixel_color,
//                                                  blit_performed
//   APB       in         psel/penable/pwrite       scroll_offset (0x0), flip_screen (0x4)
//
// A 16x16 blit makes one ROM and one video RAM read per nibble, pipelined
// against the video RAM write port. Video RAM reads and pixel fetches go
// through a read state; other items load their result when popped.
// After reset the video RAM is cleared, one byte a cycle; during this pass no
// item is accepted, but configuration writes are still taken. A stalled output
// holds the back end while the front keeps filling the 4-entry command queue.
// ============================================================================
module nibble_block_blitter_with_scanout #(
    parameter int VRAM_BYTES = nbb_pkg::VRAM_BYTES,
    parameter int ROM_BYTES  = nbb_pkg::ROM_BYTES
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    nbb_in_if.sink                     i_in,
    nbb_out_if.source                  o_out,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [nbb_pkg::APB_AW-1:0] paddr,
    input  logic [nbb_pkg::APB_DW-1:0] pwdata,
    output logic [nbb_pkg::APB_DW-1:0] prdata,
    output logic                       pready
);

    nbb_pkg::t_back_status status;
    nbb_pkg::t_entry       push_entry;
    nbb_pkg::t_entry       head_entry;
    logic                  push;
    logic                  pop;
    logic                  full;
    logic                  empty;

    nbb_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_status (status),
        .i_full   (full),
        .o_push   (push),
        .o_entry  (push_entry),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    nbb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_full  (full),
        .i_pop   (pop),
        .o_entry (head_entry),
        .o_empty (empty)
    );

    nbb_back #(
        .VRAM_BYTES (VRAM_BYTES),
        .ROM_BYTES  (ROM_BYTES)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_entry  (head_entry),
        .i_empty  (empty),
        .o_pop    (pop),
        .o_status (status),
        .o_out    (o_out)
    );

endmodule

### rtl/core/nbb_checker.sv
// ============================================================================
// nbb_checker: port-level checks of the nibble block blitter
// Watches the top-level ports and is attached with a bind.
// ============================================================================
module nbb_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input nbb_pkg::t_out_item i_out_item,
    input logic               i_pready
);

    // A pending result is never withdrawn.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result withdrawn while stalled");

    // A result carries at most one kind of data.
    a_one_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_out_item.read_data != 8'd0 && i_out_item.pixel_color != 4'd0)
                        && !(i_out_item.blit_performed
                             && (i_out_item.read_data != 8'd0
                                 || i_out_item.pixel_color != 4'd0)))
        else $error("result mixes read, pixel and blit data");

    // Right after reset the clearing pass blocks input and no result is pending.
    a_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !i_in_ready && !i_out_valid && !(i_in_valid && i_in_ready))
        else $error("activity right after reset");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pready)
        else $error("configuration port inserted a wait state");

endmodule

bind nibble_block_blitter_with_scanout nbb_checker u_nbb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_item  (o_out.item),
    .i_pready    (pready)
);
